### design/rbis_pkg.sv
// ----------------------------------------------------------------------------
// rbis_pkg: shared types and constants of the rigid body step block
// Fixed formats, configuration register indexes, saturation and the small
// index helper that walks the three axes in cyclic order.
// ----------------------------------------------------------------------------
package rbis_pkg;

  // Quaternion parts are Q2.30, the time step is Q0.16.
  localparam int QUAT_BITS = 30;
  localparam int DT_BITS   = 16;

  // Multiplier operands, product and the wide accumulator.
  localparam int OPND_W = 33;
  localparam int PROD_W = 66;
  localparam int ACC_W  = 76;

  // Configuration register indexes.
  localparam logic [2:0] REG_MASS      = 3'd0;
  localparam logic [2:0] REG_INERTIA_X = 3'd1;
  localparam logic [2:0] REG_INERTIA_Y = 3'd2;
  localparam logic [2:0] REG_INERTIA_Z = 3'd3;
  localparam logic [2:0] REG_TIME_STEP = 3'd4;
  localparam logic [2:0] REG_GRAVITY_X = 3'd5;
  localparam logic [2:0] REG_GRAVITY_Y = 3'd6;
  localparam logic [2:0] REG_GRAVITY_Z = 3'd7;

  localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(2147483647);
  localparam logic signed [ACC_W-1:0] S32_MIN = ~S32_MAX;

  // Request from the sequencer to the divide / square root unit.
  typedef struct packed {
    logic start;
    logic sqrt;
  } dsq_req_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (x < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Next axis in the cycle x, y, z, x.
  function automatic logic [1:0] nxt3(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

endpackage

### design/rigid_body_integrate_step_top.sv
// ----------------------------------------------------------------------------
// rigid_body_integrate_step_top: one semi-implicit Euler rigid body step
// Integrates velocity, position, body spin and orientation for each word of
// applied force and torque and returns the new pose.
// ----------------------------------------------------------------------------
// Each input word is one timestep. A small sequencer drives one shared 33x33
// multiplier and one bit-serial divide / square root unit. An item uses 60
// products, ten divisions and one root; when the turned quaternion has zero
// length the four normalizing divisions are left out. When mass or time step
// is zero the state is returned unchanged with the skipped flag set. The
// input is ready only while the sequencer is idle, and the result register
// lets the next word in while a result waits.
// Position, velocity and spin are Q(32-FRAC_BITS).FRAC_BITS, the quaternion
// Q2.30, and every 32-bit intermediate is saturated to 32 bits.
module rigid_body_integrate_step_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [31:0]   cfg_data,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // force_x, force_y, force_z, torque_x, torque_y, torque_z
  input  logic [191:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, quat_w, quat_x, quat_y, quat_z
  output logic [319:0]  m_axis_tdata,
  // skipped
  output logic [0:0]    m_axis_tuser
);
  import rbis_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_WB   = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } st_t;

  typedef enum logic [9:0] {
    G_LIN  = 10'b00_0000_0001,
    G_ROTT = 10'b00_0000_0010,
    G_ROTU = 10'b00_0000_0100,
    G_ROTO = 10'b00_0000_1000,
    G_MOM  = 10'b00_0001_0000,
    G_GYRO = 10'b00_0010_0000,
    G_SPIN = 10'b00_0100_0000,
    G_QUAT = 10'b00_1000_0000,
    G_SQRT = 10'b01_0000_0000,
    G_NORM = 10'b10_0000_0000
  } grp_t;

  st_t  st;
  grp_t grp, nx_grp;
  logic [1:0] ax, nx_ax, last_ax, j1, j2, ri, k1, k2;
  logic [2:0] sub, nx_sub, last_sub;
  logic       nx_end;

  // Configuration.
  logic [30:0]        mass;
  logic [30:0]        inertia [3];
  logic [15:0]        time_step;
  logic signed [31:0] gravity [3];

  // Body state.
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] spin [3];
  logic signed [31:0] quat [4];

  // Working registers of one step.
  logic signed [31:0] fv [3];
  logic signed [31:0] tq [3];
  logic signed [31:0] tv [3];
  logic signed [31:0] uv [3];
  logic signed [31:0] mom [3];
  logic signed [31:0] gy [3];
  logic signed [31:0] turned [4];
  logic signed [31:0] dw;
  logic signed [56:0] rate;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic [64:0] sum;
  logic [32:0] len;
  logic        skip;
  logic        dneg;

  // Multiplier operands and write-back terms.
  logic signed [OPND_W-1:0] op_a, op_b, dt_op;
  logic signed [OPND_W-1:0] cq [3];
  logic signed [31:0]       qv [3];
  logic signed [ACC_W-1:0]  term_f, term_q, term_d, acc_fin, acc_lo, qmag, qs;
  logic signed [56:0]       rate_next;

  // Divide / square root unit.
  dsq_req_t           dsq_req;
  logic               dsq_op;
  logic               dsq_done;
  logic [63:0]        dsq_res;
  logic [63:0]        dsq_num;
  logic [32:0]        dsq_den;
  logic signed [63:0] dvd;
  logic               sum_zero;
  logic [319:0]       out_data;
  logic               out_skip;

  assign j1 = nxt3(ax);
  assign j2 = nxt3(j1);
  assign ri = ax - 2'd1;
  assign k1 = nxt3(ri);
  assign k2 = nxt3(k1);
  assign dt_op = {17'd0, time_step};
  assign sum_zero = (sum == '0);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qv[k] = quat[k+1];
      cq[k] = -OPND_W'(quat[k+1]);
    end
  end

  // Step order: axis and sub-step counters inside each group.
  always_comb begin
    last_sub = 3'd0;
    last_ax  = 2'd2;
    unique case (grp) inside
      G_LIN:                        last_sub = 3'd3;
      G_ROTT, G_ROTU, G_GYRO, G_SPIN: last_sub = 3'd1;
      G_QUAT: begin
        last_sub = 3'd5;
        last_ax  = 2'd3;
      end
      G_NORM:                       last_ax = 2'd3;
      G_SQRT:                       last_ax = 2'd0;
      default: ;
    endcase
    nx_grp = grp;
    nx_ax  = ax;
    nx_sub = sub;
    nx_end = 1'b0;
    if (sub != last_sub) begin
      nx_sub = sub + 3'd1;
    end else begin
      nx_sub = 3'd0;
      if (ax != last_ax) begin
        nx_ax = ax + 2'd1;
      end else begin
        nx_ax = 2'd0;
        unique case (grp)
          G_LIN:   nx_grp = G_ROTT;
          G_ROTT:  nx_grp = G_ROTU;
          G_ROTU:  nx_grp = G_ROTO;
          G_ROTO:  nx_grp = G_MOM;
          G_MOM:   nx_grp = G_GYRO;
          G_GYRO:  nx_grp = G_SPIN;
          G_SPIN:  nx_grp = G_QUAT;
          G_QUAT:  nx_grp = G_SQRT;
          G_SQRT:  nx_grp = G_NORM;
          G_NORM:  nx_end = 1'b1;
          default: nx_end = 1'b1;
        endcase
      end
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (grp)
      G_LIN: begin
        case (sub)
          3'd0: begin
            op_a = {2'b00, mass};
            op_b = OPND_W'(gravity[ax]);
          end
          3'd2: begin
            op_a = OPND_W'(fv[ax]);
            op_b = dt_op;
          end
          3'd3: begin
            op_a = OPND_W'(vel[ax]);
            op_b = dt_op;
          end
          default: ;
        endcase
      end
      G_ROTT: begin
        op_a = sub[0] ? cq[j2] : cq[j1];
        op_b = OPND_W'(sub[0] ? tq[j1] : tq[j2]);
      end
      G_ROTU: begin
        op_a = sub[0] ? cq[j2] : cq[j1];
        op_b = OPND_W'(sub[0] ? tv[j1] : tv[j2]);
      end
      G_ROTO: begin
        op_a = OPND_W'(quat[0]);
        op_b = OPND_W'(tv[ax]);
      end
      G_MOM: begin
        op_a = {2'b00, inertia[ax]};
        op_b = OPND_W'(spin[ax]);
      end
      G_GYRO: begin
        op_a = OPND_W'(sub[0] ? spin[j2] : spin[j1]);
        op_b = OPND_W'(sub[0] ? mom[j1] : mom[j2]);
      end
      G_SPIN: begin
        op_a = OPND_W'(dw);
        op_b = dt_op;
      end
      G_QUAT: begin
        case (sub)
          3'd0: begin
            op_a = OPND_W'((ax == 2'd0) ? qv[0] : quat[0]);
            op_b = OPND_W'((ax == 2'd0) ? spin[0] : spin[ri]);
          end
          3'd1: begin
            op_a = OPND_W'((ax == 2'd0) ? qv[1] : qv[k1]);
            op_b = OPND_W'((ax == 2'd0) ? spin[1] : spin[k2]);
          end
          3'd2: begin
            op_a = OPND_W'((ax == 2'd0) ? qv[2] : qv[k2]);
            op_b = OPND_W'((ax == 2'd0) ? spin[2] : spin[k1]);
          end
          3'd3: begin
            op_a = rate[56:24];
            op_b = dt_op;
          end
          3'd4: begin
            op_a = {9'd0, rate[23:0]};
            op_b = dt_op;
          end
          3'd5: begin
            op_a = OPND_W'(turned[ax]);
            op_b = OPND_W'(turned[ax]);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Divider operands; the sign is taken off and put back on the quotient.
  always_comb begin
    dsq_op = (grp == G_LIN && sub == 3'd1) || (grp == G_SPIN && sub == 3'd0) ||
             grp == G_NORM || grp == G_SQRT;
    dvd     = '0;
    dsq_den = len;
    unique case (grp)
      G_LIN: begin
        dvd     = 64'(fv[ax]) <<< FRAC_BITS;
        dsq_den = {2'b00, mass};
      end
      G_SPIN: begin
        dvd     = (64'(tq[ax]) - 64'(gy[ax])) <<< FRAC_BITS;
        dsq_den = {2'b00, inertia[ax]};
      end
      G_NORM:  dvd = 64'(turned[ax]) <<< QUAT_BITS;
      default: ;
    endcase
    if (grp == G_SQRT) begin
      dsq_num = sum[64] ? '1 : sum[63:0];
    end else begin
      dsq_num = dvd[63] ? 64'(-dvd) : 64'(dvd);
    end
    dsq_req.start = (st == S_MUL) && dsq_op;
    dsq_req.sqrt  = (grp == G_SQRT);
  end

  rbis_divsqrt u_divsqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (dsq_req),
    .num  (dsq_num),
    .den  (dsq_den),
    .done (dsq_done),
    .res  (dsq_res)
  );

  // Shifted products and combined sums for write-back.
  always_comb begin
    term_f    = ACC_W'(prod >>> FRAC_BITS);
    term_q    = ACC_W'(prod >>> QUAT_BITS);
    term_d    = ACC_W'(prod >>> DT_BITS);
    acc_fin   = (ax == 2'd0) ? acc + term_f : acc - term_f;
    rate_next = (ax == 2'd0) ? 57'(-(acc_fin >>> 1)) : 57'(acc_fin >>> 1);
    acc_lo    = acc + ACC_W'(prod);
    qmag      = ACC_W'(dsq_res);
    qs        = dneg ? -qmag : qmag;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mass      <= 31'd65536;
      inertia   <= '{31'd65536, 31'd65536, 31'd65536};
      time_step <= 16'd1092;
      gravity   <= '{32'sd0, 32'sd0, 32'sd0};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MASS:      mass       <= cfg_data[30:0];
        REG_INERTIA_X: inertia[0] <= cfg_data[30:0];
        REG_INERTIA_Y: inertia[1] <= cfg_data[30:0];
        REG_INERTIA_Z: inertia[2] <= cfg_data[30:0];
        REG_TIME_STEP: time_step  <= cfg_data[15:0];
        REG_GRAVITY_X: gravity[0] <= cfg_data;
        REG_GRAVITY_Y: gravity[1] <= cfg_data;
        REG_GRAVITY_Z: gravity[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      grp           <= G_LIN;
      ax            <= 2'd0;
      sub           <= 3'd0;
      sum           <= '0;
      m_axis_tvalid <= 1'b0;
      pos           <= '{32'sd0, 32'sd0, 32'sd0};
      vel           <= '{32'sd0, 32'sd0, 32'sd0};
      spin          <= '{32'sd0, 32'sd0, 32'sd0};
      quat          <= '{32'sh40000000, 32'sd0, 32'sd0, 32'sd0};
    end else begin
      if (m_axis_tvalid && m_axis_tready && (st != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            for (int k = 0; k < 3; k++) begin
              fv[k] <= s_axis_tdata[32*k +: 32];
              tq[k] <= s_axis_tdata[96 + 32*k +: 32];
            end
            sum  <= '0;
            grp  <= G_LIN;
            ax   <= 2'd0;
            sub  <= 3'd0;
            skip <= (mass == '0) || (time_step == '0);
            st   <= ((mass == '0) || (time_step == '0)) ? S_DONE : S_MUL;
          end
        end
        S_MUL: begin
          if (dsq_op) begin
            dneg <= dvd[63];
            st   <= S_DIV;
          end else begin
            prod <= op_a * op_b;
            st   <= S_WB;
          end
        end
        S_WB: begin
          unique case (grp)
            G_LIN: begin
              case (sub)
                3'd0: fv[ax] <= sat32(ACC_W'(fv[ax]) + ACC_W'(sat32(term_f)));
                3'd2: vel[ax] <= sat32(ACC_W'(vel[ax]) + ACC_W'(sat32(term_d)));
                3'd3: pos[ax] <= sat32(ACC_W'(pos[ax]) + term_d);
                default: ;
              endcase
            end
            G_ROTT: begin
              if (sub[0]) tv[ax] <= sat32((acc - term_q) <<< 1);
              else acc <= term_q;
            end
            G_ROTU: begin
              if (sub[0]) uv[ax] <= sat32(acc - term_q);
              else acc <= term_q;
            end
            G_ROTO: tq[ax] <= sat32(ACC_W'(tq[ax]) + term_q + ACC_W'(uv[ax]));
            G_MOM:  mom[ax] <= sat32(term_f);
            G_GYRO: begin
              if (sub[0]) gy[ax] <= sat32(acc - term_f);
              else acc <= term_f;
            end
            G_SPIN: begin
              if (inertia[ax] != '0) begin
                spin[ax] <= sat32(ACC_W'(spin[ax]) + term_d);
              end
            end
            G_QUAT: begin
              case (sub)
                3'd0: acc <= term_f;
                3'd1: acc <= (ax == 2'd0) ? acc + term_f : acc + term_f;
                3'd2: rate <= rate_next;
                3'd3: acc <= ACC_W'(prod) <<< 24;
                3'd4: turned[ax] <= sat32(ACC_W'(quat[ax]) + (acc_lo >>> DT_BITS));
                3'd5: sum <= sum + {1'b0, prod[63:0]};
                default: ;
              endcase
            end
            default: ;
          endcase
          grp <= nx_grp;
          ax  <= nx_ax;
          sub <= nx_sub;
          st  <= nx_end ? S_DONE : S_MUL;
        end
        S_DIV: begin
          if (dsq_done) begin
            unique case (grp)
              G_LIN:  fv[ax]   <= sat32(qs);
              G_SPIN: dw       <= sat32(qs);
              G_SQRT: len      <= dsq_res[32:0];
              G_NORM: quat[ax] <= sat32(qs);
              default: ;
            endcase
            grp <= nx_grp;
            ax  <= nx_ax;
            sub <= nx_sub;
            st  <= (nx_end || (grp == G_SQRT && sum_zero)) ? S_DONE : S_MUL;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_data      <= {quat[3], quat[2], quat[1], quat[0],
                              vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
            out_skip      <= skip;
            m_axis_tvalid <= 1'b1;
            st            <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready   = (st == S_IDLE);
  assign m_axis_tdata    = out_data;
  assign m_axis_tuser[0] = out_skip;

  // The divider only finishes while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    dsq_done |-> st == S_DIV)
    else $error("divide unit finished outside its wait state");

  // Four squares of 32-bit values never pass two to the sixty-fourth.
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    !(sum[64] && (sum[63:0] != '0)))
    else $error("quaternion sum of squares out of range");

  // An accepted word starts the sequence or goes straight to the result.
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (st == S_MUL || st == S_DONE))
    else $error("accepted word did not start a step");

endmodule

### design/rbis_divsqrt.sv
// ----------------------------------------------------------------------------
// rbis_divsqrt: bit-serial divider and integer square root
// Restoring division of a 64-bit magnitude by a 33-bit divisor, one quotient
// bit a cycle, or a 64-bit square root, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module rbis_divsqrt (
  input  logic                clk,
  input  logic                rst,
  input  rbis_pkg::dsq_req_t  req,
  input  logic [63:0]         num,
  input  logic [32:0]         den,
  output logic                done,
  output logic [63:0]         res
);
  import rbis_pkg::*;

  logic        busy;
  logic        mode_sqrt;
  logic [6:0]  cnt;
  logic [63:0] quo;
  logic [32:0] rem;
  logic [32:0] dvs;
  logic [63:0] root;
  logic [63:0] bitv;
  logic [33:0] trial;
  logic [64:0] sq_cmp;

  // Trial remainder of the divider and trial value of the root.
  always_comb begin
    trial  = {rem, quo[63]};
    sq_cmp = {1'b0, root} + {1'b0, bitv};
  end

  // One step of the selected operation each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == 7'd1);
      if (req.start) begin
        busy      <= 1'b1;
        mode_sqrt <= req.sqrt;
        cnt       <= req.sqrt ? 7'd32 : 7'd64;
        quo       <= num;
        rem       <= '0;
        dvs       <= den;
        root      <= '0;
        bitv      <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (mode_sqrt) begin
          if ({1'b0, quo} >= sq_cmp) begin
            quo  <= quo - sq_cmp[63:0];
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
        end else begin
          if (trial >= {1'b0, dvs}) begin
            rem <= 33'(trial - {1'b0, dvs});
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= trial[32:0];
            quo <= {quo[62:0], 1'b0};
          end
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign res = mode_sqrt ? root : quo;

endmodule

### bench/rigid_body_integrate_step_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_body_integrate_step_top_tb: self-checking bench of the rigid body step
// Streams force and torque words through the block with random gaps on both
// sides. A scoreboard holds its own copy of the body state and registers and
// checks every returned pose field by field. Registers change between phases.
// ----------------------------------------------------------------------------
module rigid_body_integrate_step_top_tb;
  import rbis_pkg::*;

  localparam int FRAC = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  // Expected pose word: ten 32-bit fields and the skipped flag.
  typedef struct {
    logic [319:0] pose;
    logic         skipped;
  } pose_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the body state and predicts each returned pose.
  // --------------------------------------------------------------------------
  class pose_scoreboard;
    longint mass, inertia[3], step_dt;
    int     grav[3];
    int     pos[3], vel[3], spin[3], quat[4];
    pose_t  pending[$];
    int     errors;

    function new();
      mass = 65536;
      step_dt = 1092;
      errors = 0;
      for (int i = 0; i < 3; i++) begin
        inertia[i] = 65536;
        grav[i] = 0;
        pos[i] = 0;
        vel[i] = 0;
        spin[i] = 0;
      end
      quat[0] = 1 << QUAT_BITS;
      quat[1] = 0;
      quat[2] = 0;
      quat[3] = 0;
    endfunction

    function int clamp(longint x);
      if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return int'(x);
    endfunction

    function longint shr(longint x, int s);
      return x >>> s;
    endfunction

    function longint unsigned root64(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_MASS:      mass = longint'(val[30:0]);
        REG_INERTIA_X: inertia[0] = longint'(val[30:0]);
        REG_INERTIA_Y: inertia[1] = longint'(val[30:0]);
        REG_INERTIA_Z: inertia[2] = longint'(val[30:0]);
        REG_TIME_STEP: step_dt = longint'(val[15:0]);
        REG_GRAVITY_X: grav[0] = $signed(val);
        REG_GRAVITY_Y: grav[1] = $signed(val);
        REG_GRAVITY_Z: grav[2] = $signed(val);
        default: ;
      endcase
    endfunction

    // Rotate v by the quaternion (w, qx, qy, qz) in Q2.30.
    function void turn_vec(longint w, longint qx, longint qy, longint qz,
                           int v[3], output int o[3]);
      int t[3], u[3];
      t[0] = clamp(2 * (shr(qy * v[2], QUAT_BITS) - shr(qz * v[1], QUAT_BITS)));
      t[1] = clamp(2 * (shr(qz * v[0], QUAT_BITS) - shr(qx * v[2], QUAT_BITS)));
      t[2] = clamp(2 * (shr(qx * v[1], QUAT_BITS) - shr(qy * v[0], QUAT_BITS)));
      u[0] = clamp(shr(qy * t[2], QUAT_BITS) - shr(qz * t[1], QUAT_BITS));
      u[1] = clamp(shr(qz * t[0], QUAT_BITS) - shr(qx * t[2], QUAT_BITS));
      u[2] = clamp(shr(qx * t[1], QUAT_BITS) - shr(qy * t[0], QUAT_BITS));
      for (int i = 0; i < 3; i++)
        o[i] = clamp(longint'(v[i]) + shr(w * t[i], QUAT_BITS) + u[i]);
    endfunction

    // Advance the body one step for an accepted word and queue the pose.
    function void note_input(logic [191:0] word);
      int torque[3], tb[3], mom[3], gyro[3], turned[4];
      longint w, qx, qy, qz, rate[4], len;
      longint unsigned sum, sq;
      int gf, f, a, dv, dw;
      pose_t e;
      sum = 0;
      if (mass != 0 && step_dt != 0) begin
        for (int i = 0; i < 3; i++) begin
          gf = clamp(shr(mass * grav[i], FRAC));
          f = clamp(longint'($signed(word[32*i +: 32])) + gf);
          a = clamp(longint'(f) * 65536 / mass);
          dv = clamp(shr(longint'(a) * step_dt, DT_BITS));
          vel[i] = clamp(longint'(vel[i]) + dv);
          pos[i] = clamp(longint'(pos[i]) + shr(longint'(vel[i]) * step_dt, DT_BITS));
          torque[i] = $signed(word[32*(3+i) +: 32]);
        end
        w = quat[0];
        qx = quat[1];
        qy = quat[2];
        qz = quat[3];
        turn_vec(w, -qx, -qy, -qz, torque, tb);
        for (int i = 0; i < 3; i++)
          mom[i] = clamp(shr(inertia[i] * spin[i], FRAC));
        gyro[0] = clamp(shr(longint'(spin[1]) * mom[2], FRAC)
                        - shr(longint'(spin[2]) * mom[1], FRAC));
        gyro[1] = clamp(shr(longint'(spin[2]) * mom[0], FRAC)
                        - shr(longint'(spin[0]) * mom[2], FRAC));
        gyro[2] = clamp(shr(longint'(spin[0]) * mom[1], FRAC)
                        - shr(longint'(spin[1]) * mom[0], FRAC));
        for (int i = 0; i < 3; i++) begin
          if (inertia[i] != 0) begin
            dw = clamp((longint'(tb[i]) - gyro[i]) * 65536 / inertia[i]);
            spin[i] = clamp(longint'(spin[i]) + shr(longint'(dw) * step_dt, DT_BITS));
          end
        end
        rate[0] = -shr(shr(qx * spin[0], FRAC) + shr(qy * spin[1], FRAC)
                       + shr(qz * spin[2], FRAC), 1);
        rate[1] = shr(shr(w * spin[0], FRAC) + shr(qy * spin[2], FRAC)
                      - shr(qz * spin[1], FRAC), 1);
        rate[2] = shr(shr(w * spin[1], FRAC) + shr(qz * spin[0], FRAC)
                      - shr(qx * spin[2], FRAC), 1);
        rate[3] = shr(shr(w * spin[2], FRAC) + shr(qx * spin[1], FRAC)
                      - shr(qy * spin[0], FRAC), 1);
        for (int i = 0; i < 4; i++) begin
          turned[i] = clamp(longint'(quat[i]) + shr(rate[i] * step_dt, DT_BITS));
          sq = longint'(turned[i]) * longint'(turned[i]);
          if (sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) sum = 64'hFFFF_FFFF_FFFF_FFFF;
          else sum = sum + sq;
        end
        // A zero-length quaternion keeps the old orientation.
        if (sum != 0) begin
          len = longint'(root64(sum));
          for (int i = 0; i < 4; i++)
            quat[i] = clamp((longint'(turned[i]) <<< QUAT_BITS) / len);
        end
        e.skipped = 1'b0;
      end else begin
        e.skipped = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        e.pose[32*i +: 32] = pos[i];
        e.pose[32*(3+i) +: 32] = vel[i];
      end
      for (int i = 0; i < 4; i++) e.pose[32*(6+i) +: 32] = quat[i];
      pending.push_back(e);
    endfunction

    // Compare a returned pose with the oldest expected one.
    function void check_result(logic [319:0] pose, logic skipped);
      string names[10] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                           "quat_w", "quat_x", "quat_y", "quat_z"};
      pose_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 10; i++) begin
        if (pose[32*i +: 32] !== e.pose[32*i +: 32]) begin
          $error("%s expected %0d actual %0d", names[i],
                 $signed(e.pose[32*i +: 32]), $signed(pose[32*i +: 32]));
          errors++;
        end
      end
      if (skipped !== e.skipped) begin
        $error("skipped expected %0d actual %0d", e.skipped, skipped);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_addr = '0;
  logic [31:0]   cfg_data = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [191:0]  s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [319:0]  m_axis_tdata;
  logic [0:0]    m_axis_tuser;

  pose_scoreboard sb = new();
  bit   idle_gaps = 1'b1;
  int   quiet_cycles = 0;

  always #1 clk = ~clk;

  rigid_body_integrate_step_top dut (.*);

  // Watchdog: too long without any word moving ends the run.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rigid_body_integrate_step_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, then take and check one word.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = idle_gaps ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    end
  end

  // Mostly small magnitudes so the body moves without pinning at the rails.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return 32'($urandom_range(0, 1048575)) - 32'd524288;
    endcase
  endfunction

  task automatic send_word(logic [191:0] word);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(word);
  endtask

  task automatic send_uniform(logic [31:0] f, logic [31:0] t);
    send_word({t, t, t, f, f, f});
  endtask

  task automatic send_random();
    logic [191:0] word;
    for (int i = 0; i < 6; i++) word[32*i +: 32] = pick_value();
    send_word(word);
  endtask

  // Stop driving, then wait until every pose is back and the block has settled.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_all(logic [31:0] m, logic [31:0] ix, logic [31:0] iy,
                           logic [31:0] iz, logic [31:0] dt, logic [31:0] gx,
                           logic [31:0] gy, logic [31:0] gz);
    write_reg(REG_MASS, m);
    write_reg(REG_INERTIA_X, ix);
    write_reg(REG_INERTIA_Y, iy);
    write_reg(REG_INERTIA_Z, iz);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_GRAVITY_X, gx);
    write_reg(REG_GRAVITY_Y, gy);
    write_reg(REG_GRAVITY_Z, gz);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_moment();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h7FFFFFFF;
      2: return 32'($urandom_range(1, 255));
      3: return $urandom;
      default: return 32'($urandom_range(16384, 1048576));
    endcase
  endfunction

  function automatic logic [31:0] pick_gravity();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return $urandom;
      default: return 32'($urandom_range(0, 1310720)) - 32'd655360;
    endcase
  endfunction

  initial begin
    int dt_pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: rest state, extreme forces and torques at reset settings.
    send_uniform(32'h0, 32'h0);
    send_uniform(32'h00010000, 32'h00008000);
    send_uniform(32'h7FFFFFFF, 32'h0);
    send_uniform(32'h80000000, 32'h0);
    send_uniform(32'h0, 32'h7FFFFFFF);
    send_uniform(32'h0, 32'h80000000);
    send_word({32'h80000000, 32'h7FFFFFFF, 32'h00001000,
               32'hFFFFFFFF, 32'h00000001, 32'h7FFFFFFF});
    drain();

    // Zero mass skips the step; upper register bits are dropped.
    write_all(32'h80000000, 32'h10000, 32'h10000, 32'h10000, 32'd1092, 0, 0, 0);
    send_uniform(32'h00010000, 32'h00010000);
    drain();
    // Zero time step skips the step.
    write_all(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'hFFFF0000, 0, 0, 0);
    send_uniform(32'h00010000, 32'h00010000);
    drain();
    // Frozen x spin axis, then all-extreme registers with heavy torque.
    write_all(32'h10000, 32'h0, 32'h20000, 32'h8000, 32'd4000,
              32'hFFF63000, 32'h0, 32'h9CE80);
    send_uniform(32'h00050000, 32'h00300000);
    send_uniform(32'hFFFB0000, 32'hFFE00000);
    drain();
    write_all(32'h7FFFFFFF, 32'h1, 32'h7FFFFFFF, 32'h1, 32'd65535,
              32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_uniform(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_uniform(32'h80000000, 32'h80000000);
    send_random();
    drain();
    write_all(32'h1, 32'h7FFFFFFF, 32'h1, 32'h7FFFFFFF, 32'd1,
              32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_random();
    send_random();
    drain();

    // Random phases, each with its own register setting.
    for (int phase = 0; phase < 10; phase++) begin
      idle_gaps = (phase % 4) != 3;
      dt_pick = $urandom_range(0, 9);
      write_all((phase == 4) ? 32'h0 : pick_moment() | 32'(phase != 4 && phase % 2 == 0),
                pick_moment(), pick_moment(), pick_moment(),
                (dt_pick == 0) ? 32'h0 : (dt_pick == 1) ? 32'hFFFF
                  : 32'($urandom_range(1, 4096)),
                pick_gravity(), pick_gravity(), pick_gravity());
      for (int n = 0; n < ((phase == 4) ? 40 : 200); n++) send_random();
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("rigid_body_integrate_step_top test passed");
    end else begin
      $display("rigid_body_integrate_step_top test failed");
    end
    $finish;
  end

endmodule
